// File: rtl/core/bls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants and types of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 10;

    // Depth of the command queue and of the pixel queue
    localparam int QUEUE_DEPTH = 2;

    // Operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Status of the back end, seen by the top level
    typedef struct packed {
        logic take;    // a command leaves the queue this cycle
        logic emit;    // a pixel is pushed into the pixel queue
        logic last;    // the pixel pushed is the last of its line
        logic active;  // pixels remain on the current line
    } t_bls_stat;

endpackage

// File: rtl/core/bls_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module bls_fifo
    import bls_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/bls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_front
// Classify an input item and set up a line: deltas, directions, steep flag.
// ----------------------------------------------------------------------------
module bls_front
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int RW = 4 * COORD_BITS + 6
) (
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic [RW-1:0]         o_rec
);

    logic                  x_up, x_down, y_up, y_down;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  steep;
    logic [COORD_BITS-1:0] major, minor;

    // Direction and absolute distance per axis
    assign x_up   = i_x_end > i_x_start;
    assign x_down = i_x_end < i_x_start;
    assign y_up   = i_y_end > i_y_start;
    assign y_down = i_y_end < i_y_start;
    assign dx     = x_up ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
    assign dy     = y_up ? (i_y_end - i_y_start) : (i_y_start - i_y_end);

    // Pick the major axis
    assign steep = dy > dx;
    assign major = steep ? dy : dx;
    assign minor = steep ? dx : dy;

    // Pack the command for the back end
    assign o_rec = {i_operation, i_x_start, i_y_start, major, minor,
                    x_down, x_up || x_down, y_down, y_up || y_down, steep};

endmodule

// File: rtl/core/bls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_back
// Hold the line state and step it, one pixel per step command on an active line.
// ----------------------------------------------------------------------------
module bls_back
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int RW = 4 * COORD_BITS + 6,
    localparam int PXW = 2 * COORD_BITS + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [RW-1:0]   i_rec,
    input  logic            i_rec_empty,
    output logic            o_rec_pop,
    output logic [PXW-1:0]  o_pix,
    output logic            o_pix_push,
    input  logic            i_pix_full,
    output t_bls_stat       o_stat
);

    localparam int DW = COORD_BITS + 3;

    // Unpacked command
    logic                  c_op;
    logic [COORD_BITS-1:0] c_x0, c_y0, c_major, c_minor;
    logic                  c_xneg, c_xmv, c_yneg, c_ymv, c_steep;

    // Line state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] r_major, n_major;
    logic [COORD_BITS-1:0] r_minor, n_minor;
    logic                  r_xneg, n_xneg, r_xmv, n_xmv;
    logic                  r_yneg, n_yneg, r_ymv, n_ymv;
    logic                  r_steep, n_steep;
    logic signed [DW-1:0]  r_dec, n_dec;
    logic [COORD_BITS-1:0] r_left, n_left;

    logic                  take;
    logic                  emit;
    logic                  fix_minor;
    logic signed [DW-1:0]  dec_mid;
    logic signed [DW-1:0]  two_major, two_minor;

    function automatic logic [COORD_BITS-1:0] step_coord(
        input logic [COORD_BITS-1:0] v,
        input logic                  mv,
        input logic                  neg
    );
        logic [COORD_BITS-1:0] r;
        if (!mv) begin
            r = v;
        end else if (neg) begin
            r = v - 1'b1;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    assign {c_op, c_x0, c_y0, c_major, c_minor,
            c_xneg, c_xmv, c_yneg, c_ymv, c_steep} = i_rec;

    // Take a command whenever the pixel queue has room
    assign take      = !i_rec_empty && !i_pix_full;
    assign o_rec_pop = take;
    assign emit      = take && (c_op == OP_STEP) && (r_left != '0);

    assign o_pix_push = emit;
    assign o_pix      = {r_cur_x, r_cur_y, (r_left == COORD_BITS'(1))};

    assign two_major = DW'(signed'({2'b00, r_major, 1'b0}));
    assign two_minor = DW'(signed'({2'b00, r_minor, 1'b0}));
    assign fix_minor = !r_dec[DW-1];
    assign dec_mid   = fix_minor ? (r_dec - two_major) : r_dec;

    // Load a new line or advance the current one
    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_major = r_major;
        n_minor = r_minor;
        n_xneg  = r_xneg;
        n_xmv   = r_xmv;
        n_yneg  = r_yneg;
        n_ymv   = r_ymv;
        n_steep = r_steep;
        n_dec   = r_dec;
        n_left  = r_left;
        if (take && (c_op == OP_START)) begin
            n_cur_x = c_x0;
            n_cur_y = c_y0;
            n_major = c_major;
            n_minor = c_minor;
            n_xneg  = c_xneg;
            n_xmv   = c_xmv;
            n_yneg  = c_yneg;
            n_ymv   = c_ymv;
            n_steep = c_steep;
            n_dec   = DW'(signed'({2'b00, c_minor, 1'b0}))
                    - DW'(signed'({3'b000, c_major}));
            n_left  = c_major;
        end else if (emit) begin
            if (r_steep) begin
                n_cur_y = step_coord(r_cur_y, r_ymv, r_yneg);
                n_cur_x = fix_minor ? step_coord(r_cur_x, r_xmv, r_xneg) : r_cur_x;
            end else begin
                n_cur_x = step_coord(r_cur_x, r_xmv, r_xneg);
                n_cur_y = fix_minor ? step_coord(r_cur_y, r_ymv, r_yneg) : r_cur_y;
            end
            n_dec  = dec_mid + two_minor;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_major <= '0;
            r_minor <= '0;
            r_xneg  <= 1'b0;
            r_xmv   <= 1'b0;
            r_yneg  <= 1'b0;
            r_ymv   <= 1'b0;
            r_steep <= 1'b0;
            r_dec   <= '0;
            r_left  <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_major <= n_major;
            r_minor <= n_minor;
            r_xneg  <= n_xneg;
            r_xmv   <= n_xmv;
            r_yneg  <= n_yneg;
            r_ymv   <= n_ymv;
            r_steep <= n_steep;
            r_dec   <= n_dec;
            r_left  <= n_left;
        end
    end

    assign o_stat.take   = take;
    assign o_stat.emit   = emit;
    assign o_stat.last   = (r_left == COORD_BITS'(1));
    assign o_stat.active = (r_left != '0);

endmodule

// File: rtl/core/bresenham_line_stepper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// All-octant Bresenham line stepper with queue interfaces on both sides.
// ----------------------------------------------------------------------------
// A start item loads two endpoints and emits nothing; each following step item
// emits one pixel of the line, start point included and end point excluded, with
// the last pixel flagged. A step on a finished or zero-length line emits nothing.
// The block takes one item per cycle and delivers one pixel per cycle unless a
// full queue holds it back: setup (deltas, directions, steep flag) is done by the
// front end as the item is pushed, and the stepper in the back end updates the
// decision term with at most one subtract and one add per pixel. A step item is
// registered in the command queue and its pixel in the pixel queue, whose head
// drives the result ports. Both queues are two entries deep; the input stalls
// only once the pixel queue and then the command queue have filled.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    localparam int RW  = 4 * COORD_BITS + 6;
    localparam int PXW = 2 * COORD_BITS + 1;

    logic [RW-1:0]  rec_in, rec_out;
    logic           rec_empty, rec_pop;
    logic [PXW-1:0] pix_in, pix_out;
    logic           pix_push, pix_full;
    t_bls_stat      stat;

    // Classify and set up
    bls_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_operation (i_operation),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .o_rec       (rec_in)
    );

    // Command queue between front and back
    bls_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .o_full  (full),
        .i_pop   (rec_pop),
        .o_data  (rec_out),
        .o_empty (rec_empty)
    );

    // Step the line
    bls_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_out),
        .i_rec_empty (rec_empty),
        .o_rec_pop   (rec_pop),
        .o_pix       (pix_in),
        .o_pix_push  (pix_push),
        .i_pix_full  (pix_full),
        .o_stat      (stat)
    );

    // Pixel queue toward the consumer
    bls_fifo #(.WIDTH(PXW), .DEPTH(QUEUE_DEPTH)) u_pix_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pix_push),
        .i_data  (pix_in),
        .o_full  (pix_full),
        .i_pop   (pop),
        .o_data  (pix_out),
        .o_empty (empty)
    );

    assign {o_pixel_x, o_pixel_y, o_last_pixel} = pix_out;

    // Never push a pixel into a full queue
    a_no_pix_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pix_push && pix_full))
        else $error("pixel pushed into full queue");

    // A pixel is only emitted while a line is active, with a command taken
    a_emit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.emit |-> (stat.active && stat.take))
        else $error("pixel emitted without active line");

    // After the last pixel the line is finished
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.emit && stat.last) |=> !stat.active)
        else $error("line still active after last pixel");

    // A transfer into the stepper always leaves a pixel slot free
    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.take |-> !pix_full)
        else $error("command taken while pixel queue full");

endmodule

// File: tb/bls_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_line_checker
// Watches both queues of the line stepper, predicts each pixel and compares.
// ----------------------------------------------------------------------------
// Every item transfer on the input side runs through a cycle-free Bresenham
// tracer with its own copy of the line state. A step on an active line queues
// the expected pixel. Every pixel transfer on the output side is compared
// field by field with the oldest queued pixel. Failures are counted.
// ----------------------------------------------------------------------------
module bls_line_checker
    import bls_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  logic          full,
    input  logic          i_operation,
    input  logic [CW-1:0] i_x_start,
    input  logic [CW-1:0] i_y_start,
    input  logic [CW-1:0] i_x_end,
    input  logic [CW-1:0] i_y_end,
    input  logic          empty,
    input  logic          pop,
    input  logic [CW-1:0] i_pixel_x,
    input  logic [CW-1:0] i_pixel_y,
    input  logic          i_last_pixel,
    output int            o_pending,
    output int            o_fail_count
);

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } t_pixel;

    t_pixel pixel_q[$];

    // Tracer state
    logic [CW-1:0] pos_x, pos_y;
    logic [CW-1:0] span_major, span_minor;
    int            dir_x, dir_y;
    logic          y_major;
    int            err_term;
    int            remaining;

    int fail_count = 0;
    int pending    = 0;

    assign o_pending    = pending;
    assign o_fail_count = fail_count;

    // Advance the tracer by one input item; queue the pixel it plots, if any
    task automatic trace_item();
        logic [CW-1:0] dx, dy;
        t_pixel        px;
        if (i_operation == OP_START) begin
            dx = (i_x_end > i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
            dy = (i_y_end > i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
            pos_x      = i_x_start;
            pos_y      = i_y_start;
            dir_x      = (i_x_end > i_x_start) ? 1 : ((i_x_end < i_x_start) ? -1 : 0);
            dir_y      = (i_y_end > i_y_start) ? 1 : ((i_y_end < i_y_start) ? -1 : 0);
            y_major    = dy > dx;
            span_major = y_major ? dy : dx;
            span_minor = y_major ? dx : dy;
            err_term   = 2 * int'(span_minor) - int'(span_major);
            remaining  = int'(span_major);
        end else if (remaining != 0) begin
            px.x    = pos_x;
            px.y    = pos_y;
            px.last = (remaining == 1);
            pixel_q.push_back(px);
            // Correct the minor axis at most once
            if (err_term >= 0) begin
                if (y_major)
                    pos_x = pos_x + dir_x[CW-1:0];
                else
                    pos_y = pos_y + dir_y[CW-1:0];
                err_term -= 2 * int'(span_major);
            end
            // Advance the major axis
            if (y_major)
                pos_y = pos_y + dir_y[CW-1:0];
            else
                pos_x = pos_x + dir_x[CW-1:0];
            err_term += 2 * int'(span_minor);
            remaining--;
        end
    endtask

    // Compare one pixel transfer with the oldest expectation
    task automatic check_pixel();
        t_pixel want;
        if (pixel_q.size() == 0) begin
            $error("pixel transfer with none expected: x=%0d y=%0d last=%0d",
                   i_pixel_x, i_pixel_y, i_last_pixel);
            fail_count++;
        end else begin
            want = pixel_q.pop_front();
            if (i_pixel_x !== want.x) begin
                $error("pixel_x: expected %0d, actual %0d", want.x, i_pixel_x);
                fail_count++;
            end
            if (i_pixel_y !== want.y) begin
                $error("pixel_y: expected %0d, actual %0d", want.y, i_pixel_y);
                fail_count++;
            end
            if (i_last_pixel !== want.last) begin
                $error("last_pixel: expected %0d, actual %0d", want.last, i_last_pixel);
                fail_count++;
            end
        end
    endtask

    // Sample both queues at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_x      = '0;
            pos_y      = '0;
            span_major = '0;
            span_minor = '0;
            dir_x      = 0;
            dir_y      = 0;
            y_major    = 1'b0;
            err_term   = 0;
            remaining  = 0;
            pixel_q.delete();
        end else begin
            if (pop && !empty)
                check_pixel();
            if (push && !full)
                trace_item();
        end
        pending = pixel_q.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Bresenham line stepper.
// ----------------------------------------------------------------------------
// A directed set covers shallow, steep, diagonal, axis-aligned, zero-length and
// exhausted lines, restarts mid-line and extreme coordinates. Random lines
// follow, mostly short and complete, some cut off by a restart, plus the opening
// stretch of one full-span line. Both sides idle at random; the pixel side holds
// off once for a long stretch so the block fills, and the item side drains once.
// ----------------------------------------------------------------------------
module testbench;
    import bls_pkg::*;

    localparam int CW         = COORD_BITS_DEF;
    localparam int CMAX       = (1 << CW) - 1;
    localparam int ITEM_GOAL  = 425;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          push        = 1'b0;
    logic          pop         = 1'b0;
    logic          i_operation = OP_STEP;
    logic [CW-1:0] i_x_start   = '0;
    logic [CW-1:0] i_y_start   = '0;
    logic [CW-1:0] i_x_end     = '0;
    logic [CW-1:0] i_y_end     = '0;
    logic          full;
    logic          empty;
    logic [CW-1:0] o_pixel_x;
    logic [CW-1:0] o_pixel_y;
    logic          o_last_pixel;

    int pending;
    int fail_count;
    int items_sent = 0;
    int cycles     = 0;
    int tx_gap_max = 8;
    int rx_gap_max = 8;
    bit hold_req   = 1'b0;

    bresenham_line_stepper_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

    bls_line_checker #(.CW(CW)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .empty        (empty),
        .pop          (pop),
        .i_pixel_x    (o_pixel_x),
        .i_pixel_y    (o_pixel_y),
        .i_last_pixel (o_last_pixel),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Pixel side: random idle per transfer, one long hold-off on request
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_LEN) begin
                    @(negedge i_clk);
                    pop = 1'b0;
                end
            end
            if ($urandom_range(0, 15) == 0)
                rx_gap_max = (rx_gap_max == 0) ? 8 : 0;
            gap = $urandom_range(0, rx_gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                pop = 1'b0;
            end
            @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Offer one item after a random idle stretch; hold it until the transfer
    task automatic send_item(input logic op, input int xs, input int ys,
                             input int xe, input int ye);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push        = 1'b1;
        i_operation = op;
        i_x_start   = xs[CW-1:0];
        i_y_start   = ys[CW-1:0];
        i_x_end     = xe[CW-1:0];
        i_y_end     = ye[CW-1:0];
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    // Start a line, then issue a number of steps with random don't-care fields
    task automatic run_line(input int xs, input int ys, input int xe, input int ye,
                            input int steps);
        send_item(OP_START, xs, ys, xe, ye);
        repeat (steps)
            send_item(OP_STEP, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                      $urandom_range(0, CMAX), $urandom_range(0, CMAX));
    endtask

    // Hold the item side until every expected pixel has arrived
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Mostly short lines run to the end and past it; some cut off by a restart
    task automatic random_line();
        int xs, ys, xe, ye, ox, oy, major, steps;
        xs = $urandom_range(0, CMAX);
        ys = $urandom_range(0, CMAX);
        if ($urandom_range(0, 9) == 0) begin
            xe = $urandom_range(0, 1) ? CMAX : 0;
            ye = $urandom_range(0, CMAX);
        end else begin
            ox = $urandom_range(0, 12);
            oy = $urandom_range(0, 12);
            xe = $urandom_range(0, 1) ? xs + ox : xs - ox;
            ye = $urandom_range(0, 1) ? ys + oy : ys - oy;
            if (xe < 0 || xe > CMAX) xe = 2 * xs - xe;
            if (ye < 0 || ye > CMAX) ye = 2 * ys - ye;
        end
        ox    = (xe > xs) ? xe - xs : xs - xe;
        oy    = (ye > ys) ? ye - ys : ys - ye;
        major = (ox > oy) ? ox : oy;
        if ($urandom_range(0, 3) == 0)
            steps = $urandom_range(0, major);
        else
            steps = major + $urandom_range(0, 2);
        if (steps > 40)
            steps = $urandom_range(20, 40);
        run_line(xs, ys, xe, ye, steps);
    endtask

    initial begin
        int line_idx;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: step with no line, all axis classes, extremes, restarts
        send_item(OP_STEP, CMAX, CMAX, CMAX, CMAX);
        run_line(CMAX, 0, CMAX - 3, 2, 4);
        run_line(0, CMAX, 2, CMAX - 4, 5);
        run_line(512, 512, 512, 512, 1);
        run_line(0, 0, CMAX, CMAX, 3);
        run_line(CMAX, CMAX, CMAX, CMAX - 2, 3);
        run_line(5, 7, 7, 7, 2);
        drain();

        // Random lines
        line_idx = 0;
        while (items_sent < ITEM_GOAL) begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            if (line_idx == 8) begin
                // Stall the pixel side while items keep coming
                hold_req   = 1'b1;
                tx_gap_max = 0;
                run_line(100, 200, 140, 210, 30);
            end else if (line_idx == 16) begin
                drain();
            end else if (line_idx == 24) begin
                run_line(0, CMAX, CMAX, 0, 40);
            end else begin
                random_line();
            end
            line_idx++;
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
